// File: rtl/core/rrts_pkg.sv
// Package for the round-robin task scheduler core.
// Holds shared constants, operation/error/state codes and default sizes.
// No dependencies; compiled first.
`default_nettype none

package rrts_pkg;

   // Default sizes handed to the top level as parameter defaults.
   localparam int QUEUE_DEPTH_DEFAULT  = 16;
   localparam int TASK_ID_BITS_DEFAULT = 8;

   // Fixed field widths of the item payloads.
   localparam int OP_W     = 2;
   localparam int DEVICE_W = 2;
   localparam int TASK_W   = 8;
   localparam int COUNT_W  = 5;
   localparam int ERROR_W  = 2;

   // Number of device blocking queues (keyboard, disk, video).
   localparam int NUM_DEVICES = 3;

   // Device codes. The code zero selects no queue.
   localparam logic [DEVICE_W-1:0] DEV_NONE     = 2'd0;
   localparam logic [DEVICE_W-1:0] DEV_KEYBOARD = 2'd1;
   localparam logic [DEVICE_W-1:0] DEV_DISK     = 2'd2;
   localparam logic [DEVICE_W-1:0] DEV_VIDEO    = 2'd3;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_BLOCK = 2'd1,
      OP_WAKE  = 2'd2,
      OP_ADMIT = 2'd3
   } op_type;

   typedef enum logic [ERROR_W-1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2,
      ERR_BAD   = 2'd3
   } err_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

`default_nettype wire

// File: rtl/core/rrts_if.sv
// Handshake interfaces for the scheduler's request and response channels.
// Depends on rrts_pkg for the payload widths.
`default_nettype none

interface rrts_req_if;
   logic                          valid;
   logic                          ready;
   logic [rrts_pkg::OP_W-1:0]     op;
   logic [rrts_pkg::DEVICE_W-1:0] device;
   logic [rrts_pkg::TASK_W-1:0]   task_id;

   modport source (output valid, output op, output device, output task_id, input ready);
   modport sink   (input valid, input op, input device, input task_id, output ready);
endinterface

interface rrts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rrts_pkg::TASK_W-1:0]  running_task;
   logic                         running_idle;
   logic [rrts_pkg::COUNT_W-1:0] ready_count;
   logic [rrts_pkg::ERROR_W-1:0] error;

   modport source (output valid, output running_task, output running_idle,
                   output ready_count, output error, input ready);
   modport sink   (input valid, input running_task, input running_idle,
                   input ready_count, input error, output ready);
endinterface

`default_nettype wire

// File: rtl/core/round_robin_task_scheduler_core.sv
// Top level of the round-robin task scheduler: queue memories, pointers and control.
// Depends on rrts_pkg and on the interfaces in rrts_if.sv.
`default_nettype none

// Channel    Direction  Handshake      Payload
// req_chan   in         valid/ready    op, device, task_id
// rsp_chan   out        valid/ready    running_task, running_idle, ready_count, error
//
// Each item has an accept and an execute cycle: in the accept cycle the heads
// of the ready queue and of the addressed device queue are read from their
// memories; in the execute cycle the read data is used, the write-back happens
// and the result lands in the output register; no item is taken during execute.
// Synchronous active-high reset empties all queues and marks the block idle;
// queue storage is not cleared, since no entry is read before it is written.
// A stalled response channel holds the result in the output register; the
// next item is taken as soon as that register is being emptied.

module round_robin_task_scheduler_core #(
   parameter int QUEUE_DEPTH  = rrts_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int TASK_ID_BITS = rrts_pkg::TASK_ID_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rrts_req_if.sink   req_chan,
   rrts_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam int DEV_W = $clog2(rrts_pkg::NUM_DEVICES);

   // Queue storage. The device queues share one memory, one row per device.
   logic [TASK_ID_BITS-1:0] ready_mem [QUEUE_DEPTH];
   logic [TASK_ID_BITS-1:0] dev_mem   [rrts_pkg::NUM_DEVICES][QUEUE_DEPTH];

   // Control state.
   rrts_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] rhead_ff, rhead_in;
   logic [CNT_W-1:0] rcount_ff, rcount_in;
   logic [IDX_W-1:0] dhead_ff  [rrts_pkg::NUM_DEVICES];
   logic [IDX_W-1:0] dhead_in  [rrts_pkg::NUM_DEVICES];
   logic [CNT_W-1:0] dcount_ff [rrts_pkg::NUM_DEVICES];
   logic [CNT_W-1:0] dcount_in [rrts_pkg::NUM_DEVICES];
   logic [TASK_ID_BITS-1:0] cur_ff, cur_in;
   logic idle_ff, idle_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Item latched at acceptance.
   rrts_pkg::op_type        op_ff;
   logic [DEV_W-1:0]        di_ff;
   logic                    dev_bad_ff;
   logic [TASK_ID_BITS-1:0] tid_ff;

   // Memory read data, registered.
   logic [TASK_ID_BITS-1:0] ready_rdata_ff;
   logic [TASK_ID_BITS-1:0] dev_rdata_ff;

   // Response payload registers.
   logic [rrts_pkg::TASK_W-1:0]  rsp_task_ff, rsp_task_in;
   logic                         rsp_idle_ff, rsp_idle_in;
   logic [rrts_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   rrts_pkg::err_type            rsp_err_ff, rsp_err_in;

   logic req_ready;
   logic accept;
   logic exec_en;
   logic [DEV_W-1:0] di_req;

   // Write ports of the two memories.
   logic                    ready_we;
   logic [TASK_ID_BITS-1:0] ready_wdata;
   logic                    dev_we;

   // Pointer arithmetic.
   logic [SUM_W-1:0] rsum, dsum;
   logic [IDX_W-1:0] rtail, dtail, rhead_nx, dhead_nx;
   logic             r_empty, r_full, d_empty, d_full;
   rrts_pkg::err_type err;

   // Map the device code to a queue row; the invalid code reads row zero, and a
   // block or wake item with that code is rejected before anything is written.
   always_comb begin
      unique case (req_chan.device)
         rrts_pkg::DEV_DISK:  di_req = DEV_W'(1);
         rrts_pkg::DEV_VIDEO: di_req = DEV_W'(2);
         default:             di_req = DEV_W'(0);
      endcase
   end

   // ---------------- Control FSM ----------------
   always_comb begin
      unique case (state_ff)
         rrts_pkg::ST_IDLE: state_in = accept ? rrts_pkg::ST_EXEC : rrts_pkg::ST_IDLE;
         rrts_pkg::ST_EXEC: state_in = rrts_pkg::ST_IDLE;
         default:           state_in = rrts_pkg::ST_IDLE;
      endcase
   end

   // No item is taken while reset is held.
   always_comb begin
      req_ready = !reset && (state_ff == rrts_pkg::ST_IDLE) &&
                  (!rsp_valid_ff || rsp_chan.ready);
      accept    = req_chan.valid && req_ready;
      exec_en   = (state_ff == rrts_pkg::ST_EXEC);
   end

   // ---------------- Pointer arithmetic ----------------
   always_comb begin
      rsum     = SUM_W'(rhead_ff) + SUM_W'(rcount_ff);
      rtail    = (rsum >= SUM_W'(QUEUE_DEPTH)) ? IDX_W'(rsum - SUM_W'(QUEUE_DEPTH))
                                               : IDX_W'(rsum);
      rhead_nx = (rhead_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rhead_ff + 1'b1;
      r_empty  = (rcount_ff == '0);
      r_full   = (rcount_ff == CNT_W'(QUEUE_DEPTH));

      dsum     = SUM_W'(dhead_ff[di_ff]) + SUM_W'(dcount_ff[di_ff]);
      dtail    = (dsum >= SUM_W'(QUEUE_DEPTH)) ? IDX_W'(dsum - SUM_W'(QUEUE_DEPTH))
                                               : IDX_W'(dsum);
      dhead_nx = (dhead_ff[di_ff] == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                              : dhead_ff[di_ff] + 1'b1;
      d_empty  = (dcount_ff[di_ff] == '0);
      d_full   = (dcount_ff[di_ff] == CNT_W'(QUEUE_DEPTH));
   end

   // ---------------- Operation datapath ----------------
   // All error checks use the counts as they stood when the item arrived,
   // which is also what the registers hold during the execute cycle.
   always_comb begin
      cur_in      = cur_ff;
      idle_in     = idle_ff;
      rhead_in    = rhead_ff;
      rcount_in   = rcount_ff;
      dhead_in    = dhead_ff;
      dcount_in   = dcount_ff;
      err         = rrts_pkg::ERR_OK;
      ready_we    = 1'b0;
      ready_wdata = cur_ff;
      dev_we      = 1'b0;

      if (exec_en) begin
         unique case (op_ff)
            rrts_pkg::OP_TICK: begin
               if (!idle_ff) begin
                  // The running task goes to the tail and the head is popped.
                  // Push plus pop leaves the count alone; with an empty queue
                  // the task just pushed is the one popped back.
                  ready_we = 1'b1;
                  rhead_in = rhead_nx;
                  if (!r_empty) begin
                     cur_in = ready_rdata_ff;
                  end
               end else if (!r_empty) begin
                  cur_in    = ready_rdata_ff;
                  idle_in   = 1'b0;
                  rhead_in  = rhead_nx;
                  rcount_in = rcount_ff - 1'b1;
               end
            end
            rrts_pkg::OP_BLOCK: begin
               priority if (dev_bad_ff || idle_ff) begin
                  err = rrts_pkg::ERR_BAD;
               end else if (d_full) begin
                  err = rrts_pkg::ERR_FULL;
               end else begin
                  dev_we           = 1'b1;
                  dcount_in[di_ff] = dcount_ff[di_ff] + 1'b1;
                  if (!r_empty) begin
                     cur_in    = ready_rdata_ff;
                     idle_in   = 1'b0;
                     rhead_in  = rhead_nx;
                     rcount_in = rcount_ff - 1'b1;
                  end else begin
                     idle_in = 1'b1;
                  end
               end
            end
            rrts_pkg::OP_WAKE: begin
               priority if (dev_bad_ff) begin
                  err = rrts_pkg::ERR_BAD;
               end else if (d_empty) begin
                  err = rrts_pkg::ERR_EMPTY;
               end else if (r_full) begin
                  err = rrts_pkg::ERR_FULL;
               end else begin
                  ready_we         = 1'b1;
                  ready_wdata      = dev_rdata_ff;
                  rcount_in        = rcount_ff + 1'b1;
                  dhead_in[di_ff]  = dhead_nx;
                  dcount_in[di_ff] = dcount_ff[di_ff] - 1'b1;
               end
            end
            rrts_pkg::OP_ADMIT: begin
               if (r_full) begin
                  err = rrts_pkg::ERR_FULL;
               end else begin
                  ready_we    = 1'b1;
                  ready_wdata = tid_ff;
                  if (idle_ff) begin
                     // Push and dispatch in one step: the count is unchanged.
                     idle_in  = 1'b0;
                     rhead_in = rhead_nx;
                     cur_in   = r_empty ? tid_ff : ready_rdata_ff;
                  end else begin
                     rcount_in = rcount_ff + 1'b1;
                  end
               end
            end
            default: begin
               err = rrts_pkg::ERR_OK;
            end
         endcase
      end
   end

   // Response register: loaded in the execute cycle, emptied on handshake.
   always_comb begin
      rsp_task_in  = rsp_task_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;
      if (exec_en) begin
         rsp_valid_in = 1'b1;
         rsp_task_in  = idle_in ? '0 : rrts_pkg::TASK_W'(cur_in);
         rsp_idle_in  = idle_in;
         rsp_count_in = rrts_pkg::COUNT_W'(rcount_in);
         rsp_err_in   = err;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------- Registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrts_pkg::ST_IDLE;
         rhead_ff     <= '0;
         rcount_ff    <= '0;
         dhead_ff     <= '{default: '0};
         dcount_ff    <= '{default: '0};
         cur_ff       <= '0;
         idle_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rhead_ff     <= rhead_in;
         rcount_ff    <= rcount_in;
         dhead_ff     <= dhead_in;
         dcount_ff    <= dcount_in;
         cur_ff       <= cur_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_task_ff  <= rsp_task_in;
      rsp_idle_ff  <= rsp_idle_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
      if (accept) begin
         op_ff      <= rrts_pkg::op_type'(req_chan.op);
         di_ff      <= di_req;
         dev_bad_ff <= (req_chan.device == rrts_pkg::DEV_NONE);
         tid_ff     <= TASK_ID_BITS'(req_chan.task_id);
      end
   end

   // ---------------- Queue memories ----------------
   // Reads happen in the accept cycle, writes in the execute cycle that follows,
   // so a read and a write of the same entry never fall in one cycle.
   always_ff @(posedge clock) begin
      if (ready_we) begin
         ready_mem[rtail] <= ready_wdata;
      end
      if (accept) begin
         ready_rdata_ff <= ready_mem[rhead_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (dev_we) begin
         dev_mem[di_ff][dtail] <= cur_ff;
      end
      if (accept) begin
         dev_rdata_ff <= dev_mem[di_req][dhead_ff[di_req]];
      end
   end

   // ---------------- Ports ----------------
   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.running_task = rsp_task_ff;
   assign rsp_chan.running_idle = rsp_idle_ff;
   assign rsp_chan.ready_count  = rsp_count_ff;
   assign rsp_chan.error        = rsp_err_ff;

   // ---------------- Assertions ----------------
   // The ready queue count never passes the queue depth.
   a_rcount_bound: assert property (@(posedge clock) disable iff (reset)
      rcount_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("ready queue count exceeds depth");

   // An accepted item is executed in the very next cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> exec_en)
      else $error("accepted item not executed");

   // A new result only appears after an execute cycle.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(exec_en))
      else $error("result raised without an executed item");

   // The output register is free whenever an item executes.
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      exec_en |-> !rsp_valid_ff)
      else $error("result overwritten before delivery");

endmodule

`default_nettype wire
